@@ sv/rlp_pkg.sv @@
`default_nettype none

package rlp_pkg;

  // Bytes in the length field of an input request.
  localparam int LEN_BYTES = 4;
  // Most length bytes that a long header may carry.
  localparam int LEN_BYTES_MAX = 4;
  // Width of a length-byte count (0 to LEN_BYTES).
  localparam int NW = $clog2(LEN_BYTES + 1);
  // Width of an index into the length bytes.
  localparam int IW = (LEN_BYTES > 1) ? $clog2(LEN_BYTES) : 1;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  // Header bases and thresholds.
  localparam logic [7:0] STR_SHORT_BASE  = 8'h80;
  localparam logic [7:0] STR_LONG_BASE   = 8'hb7;
  localparam logic [7:0] LIST_SHORT_BASE = 8'hc0;
  localparam logic [7:0] LIST_LONG_BASE  = 8'hf7;
  localparam logic [7:0] STR_ONE_BYTE    = 8'h81;
  localparam logic [31:0] SHORT_MAX      = 32'd55;
  localparam logic [7:0] SELF_MAX        = 8'd127;

  // Request actions.
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_LIST  = 2'd2
  } action_t;

  // One command for the back end: a head byte, then tail_len bytes taken
  // from len, most significant first.
  typedef struct packed {
    logic [7:0]            head;
    logic                  head_complete;
    logic                  head_error;
    logic [NW-1:0]         tail_len;
    logic                  tail_complete;
    logic [8*LEN_BYTES-1:0] len;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/rlp_front.sv @@
`default_nettype none

module rlp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [31:0]           length,
  input  logic [7:0]            data_byte,
  input  logic                  q_full,
  output logic                  push,
  output rlp_pkg::cmd_t         cmd
);
  import rlp_pkg::*;

  logic [31:0]   bytes_remaining;
  logic [31:0]   bytes_remaining_next;
  logic          single_pending;
  logic          single_pending_next;
  logic          accept;
  logic [NW-1:0] n;
  logic          too_long;

  // A request is taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Number of significant bytes in the length.
  always_comb begin
    n = '0;
    for (int i = 0; i < LEN_BYTES; i++) begin
      if (length[8*i +: 8] != 8'd0) begin
        n = NW'(i + 1);
      end
    end
    too_long = int'(n) > LEN_BYTES_MAX;
  end

  // Classify the request and build the command for the back end.
  always_comb begin
    bytes_remaining_next = bytes_remaining;
    single_pending_next  = single_pending;
    push = 1'b0;
    cmd  = '0;
    case (action)
      ACT_START: begin
        bytes_remaining_next = '0;
        single_pending_next  = 1'b0;
        if (length == 32'd0) begin
          push = 1'b1;
          cmd.head = STR_SHORT_BASE;
          cmd.head_complete = 1'b1;
        end else if (length == 32'd1) begin
          single_pending_next = 1'b1;
        end else if (length <= SHORT_MAX) begin
          push = 1'b1;
          cmd.head = STR_SHORT_BASE + length[7:0];
          bytes_remaining_next = length;
        end else if (too_long) begin
          push = 1'b1;
          cmd.head_error = 1'b1;
        end else begin
          push = 1'b1;
          cmd.head = STR_LONG_BASE + 8'(n);
          cmd.tail_len = n;
          cmd.len = length;
          bytes_remaining_next = length;
        end
      end
      ACT_DATA: begin
        push = 1'b1;
        if (single_pending) begin
          single_pending_next  = 1'b0;
          bytes_remaining_next = '0;
          if (data_byte == 8'd0) begin
            cmd.head = STR_SHORT_BASE;
            cmd.head_complete = 1'b1;
          end else if (data_byte <= SELF_MAX) begin
            cmd.head = data_byte;
            cmd.head_complete = 1'b1;
          end else begin
            cmd.head = STR_ONE_BYTE;
            cmd.tail_len = NW'(1);
            cmd.tail_complete = 1'b1;
            cmd.len = {{(8*LEN_BYTES-8){1'b0}}, data_byte};
          end
        end else if (bytes_remaining != 32'd0) begin
          bytes_remaining_next = bytes_remaining - 32'd1;
          cmd.head = data_byte;
          cmd.head_complete = (bytes_remaining == 32'd1);
        end else begin
          cmd.head_error = 1'b1;
        end
      end
      ACT_LIST: begin
        bytes_remaining_next = '0;
        single_pending_next  = 1'b0;
        push = 1'b1;
        if (length <= SHORT_MAX) begin
          cmd.head = LIST_SHORT_BASE + length[7:0];
          cmd.head_complete = (length == 32'd0);
        end else if (too_long) begin
          cmd.head_error = 1'b1;
        end else begin
          cmd.head = LIST_LONG_BASE + 8'(n);
          cmd.tail_len = n;
          cmd.len = length;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
    if (!accept) begin
      push = 1'b0;
      bytes_remaining_next = bytes_remaining;
      single_pending_next  = single_pending;
    end
  end

  // Open-item state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      single_pending  <= 1'b0;
    end else begin
      bytes_remaining <= bytes_remaining_next;
      single_pending  <= single_pending_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/rlp_queue.sv @@
`default_nettype none

module rlp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rlp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rlp_pkg::cmd_t head_cmd
);
  import rlp_pkg::*;

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == QCW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QAW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QAW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/rlp_back.sv @@
`default_nettype none

module rlp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rlp_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          last_of_run,
  output logic          item_complete,
  output logic          error
);
  import rlp_pkg::*;

  cmd_t           cur;
  logic           busy;
  logic [IW-1:0]  idx;
  logic           advance;

  // The output register may load when it is empty or being taken.
  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !busy && q_valid;

  // Emit the head of a new command, then its tail bytes one per cycle while out_stall is low.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else if (advance) begin
      if (busy) begin
        out_valid     <= 1'b1;
        out_byte      <= cur.len[8*idx +: 8];
        last_of_run   <= (idx == '0);
        item_complete <= (idx == '0) && cur.tail_complete;
        error         <= 1'b0;
        if (idx == '0) begin
          busy <= 1'b0;
        end else begin
          idx <= idx - 1'b1;
        end
      end else if (q_valid) begin
        out_valid     <= 1'b1;
        out_byte      <= q_cmd.head;
        last_of_run   <= (q_cmd.tail_len == '0);
        item_complete <= q_cmd.head_complete;
        error         <= q_cmd.head_error;
        if (q_cmd.tail_len != '0) begin
          busy <= 1'b1;
          cur  <= q_cmd;
          idx  <= IW'(q_cmd.tail_len - 1'b1);
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/rlp_header_encoder.sv @@
// Streaming framer for Recursive Length Prefix byte strings and list headers.
// Input channel: in_valid/in_stall with action, length and data_byte. A start
// request opens a byte string and, unless its length is one, emits its header;
// data requests pass the payload bytes, and a list request emits a list header.
// Output channel: out_valid/out_stall with out_byte, last_of_run (final byte
// caused by one request), item_complete (byte that ends an item) and error.
// The first byte of a request is written into the command queue and then
// loaded into the output register before it is offered on the output.
// Rate: one request per cycle while each request gives at most one byte and
// out_stall is low; a long header gives its head, then n length bytes, and a
// high single-byte string 0x81, then its byte. The 1-byte output stage sets the rate.
// A two-entry command queue sits between the classifying front end and the
// output stage, so requests keep being taken while a byte waits to be taken.
// in_stall rises only when that queue is full.
// When out_stall is high the output byte and its flags hold, the queue fills
// and then in_stall stalls the sender. Requests that give no byte (a
// length-one start, an unused action) are taken without queue space use.
// Reset (rst, synchronous) empties the queue and the output stage and closes
// any open item.
`default_nettype none

module rlp_header_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        item_complete,
  output logic        error
);
  import rlp_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  // Front end: state of the open item and classification.
  rlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .length    (length),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Command queue.
  rlp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  // Back end: byte sequencer and output register.
  rlp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .item_complete (item_complete),
    .error         (error)
  );

endmodule

`default_nettype wire

@@ sv/rlp_checker.sv @@
`default_nettype none

module rlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  action,
  input logic [31:0] length,
  input logic [7:0]  data_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        last_of_run,
  input logic        item_complete,
  input logic        error
);

  // Nothing is offered on the output in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // An error request is a lone zero byte that ends its run.
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (out_byte == 8'd0 && last_of_run && !item_complete))
    else $error("malformed error request");

  // The byte that ends an item is always the last of its run.
  a_complete_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_complete) |-> last_of_run)
    else $error("item ends before its run ends");

  // A stalled output request stays and holds its byte.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte)))
    else $error("stalled output changed");

endmodule

bind rlp_header_encoder rlp_checker u_chk (.*);

`default_nettype wire
